// ===== rtl/core/lcdq_pkg.sv =====
package lcdq_pkg;

   // request modes
   localparam logic [2:0] MODE_PUT_CHAR   = 3'd0;
   localparam logic [2:0] MODE_PUT_CLEAR  = 3'd1;
   localparam logic [2:0] MODE_PUT_HOME   = 3'd2;
   localparam logic [2:0] MODE_PUT_LOCATE = 3'd3;
   localparam logic [2:0] MODE_SERVICE    = 3'd4;

   // response kinds
   localparam logic [1:0] KIND_CMD   = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;
   localparam logic [1:0] KIND_PAUSE = 2'd3;

   // token bytes held in the ring
   localparam logic [7:0] TOKEN_HOME       = 8'h80;
   localparam logic [7:0] TOKEN_CLEAR      = 8'h90;
   localparam logic [3:0] TOKEN_LOCATE_HI  = 4'hA;

   // token class in bits 6..4
   localparam logic [2:0] CLASS_HOME   = 3'd0;
   localparam logic [2:0] CLASS_CLEAR  = 3'd1;
   localparam logic [2:0] CLASS_LOCATE = 3'd2;

   // controller commands
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] CMD_SET_ADDR = 8'h80;

   // custom glyph codes folded onto 0..7
   localparam logic [7:0] GLYPH_FIRST = 8'h80;
   localparam logic [7:0] GLYPH_LAST  = 8'h87;

   // queued operation codes
   localparam logic [1:0] OP_PUT_ONE = 2'd0;
   localparam logic [1:0] OP_PUT_TWO = 2'd1;
   localparam logic [1:0] OP_SERVICE = 2'd2;

   // register map
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_ONE_BASE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_TWO_BASE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_THREE_BASE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_FOUR_BASE  = 3'd4;

   // register reset values
   localparam logic [2:0] ROW_COUNT_RESET       = 3'd2;
   localparam logic [6:0] LINE_ONE_BASE_RESET   = 7'd0;
   localparam logic [6:0] LINE_TWO_BASE_RESET   = 7'd64;
   localparam logic [6:0] LINE_THREE_BASE_RESET = 7'd20;
   localparam logic [6:0] LINE_FOUR_BASE_RESET  = 7'd84;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] char_code;
      logic [3:0] row;
      logic [7:0] column;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic       long_wait;
   } rsp_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
   } op_type;

   typedef struct packed {
      logic [2:0] row_count;
      logic [6:0] line_one_base;
      logic [6:0] line_two_base;
      logic [6:0] line_three_base;
      logic [6:0] line_four_base;
   } cfg_type;

endpackage

// ===== rtl/core/lcdq_ram.sv =====
module lcdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lcdq_front.sv =====
module lcdq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lcdq_pkg::req_type req_data,
   output logic             op_valid,
   input  logic             op_ready,
   output lcdq_pkg::op_type op_data
);

   lcdq_pkg::op_type cls_op;
   logic             cls_keep;

   lcdq_pkg::op_type fifo_ff [2];
   logic             wp_ff, wp_in;
   logic             rp_ff, rp_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   // classify the request into ring operations
   always_comb begin
      cls_keep           = 1'b1;
      cls_op.op          = lcdq_pkg::OP_PUT_ONE;
      cls_op.first_byte  = req_data.char_code;
      cls_op.second_byte = req_data.column;
      case (req_data.mode)
         lcdq_pkg::MODE_PUT_CHAR: begin
            if (req_data.char_code inside {[lcdq_pkg::GLYPH_FIRST:lcdq_pkg::GLYPH_LAST]}) begin
               cls_op.first_byte = {5'd0, req_data.char_code[2:0]};
            end
         end
         lcdq_pkg::MODE_PUT_CLEAR: begin
            cls_op.first_byte = lcdq_pkg::TOKEN_CLEAR;
         end
         lcdq_pkg::MODE_PUT_HOME: begin
            cls_op.first_byte = lcdq_pkg::TOKEN_HOME;
         end
         lcdq_pkg::MODE_PUT_LOCATE: begin
            cls_op.op         = lcdq_pkg::OP_PUT_TWO;
            cls_op.first_byte = {lcdq_pkg::TOKEN_LOCATE_HI, req_data.row};
         end
         lcdq_pkg::MODE_SERVICE: begin
            cls_op.op = lcdq_pkg::OP_SERVICE;
         end
         default: begin
            cls_keep = 1'b0;
         end
      endcase
   end

   // two-entry operation queue towards the back end
   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready && cls_keep;
   assign op_valid  = (count_ff != 2'd0);
   assign pop       = op_valid && op_ready;
   assign op_data   = fifo_ff[rp_ff];

   always_comb begin
      wp_in    = push ? ~wp_ff : wp_ff;
      rp_in    = pop ? ~rp_ff : rp_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wp_ff] <= cls_op;
      end
   end

endmodule

// ===== rtl/core/lcdq_back.sv =====
module lcdq_back #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_valid,
   output logic              op_ready,
   input  lcdq_pkg::op_type  op_data,
   input  lcdq_pkg::cfg_type cfg,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lcdq_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_PUT2   = 2'd1;
   localparam logic [1:0] S_DECODE = 2'd2;
   localparam logic [1:0] S_LOCATE = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  wr_ff, wr_in;
   logic [IDX_W-1:0]  rd_ff, rd_in;
   logic [7:0]        second_ff, second_in;
   logic [3:0]        row_ff, row_in;
   logic              col_zero_ff, col_zero_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lcdq_pkg::rsp_type rsp_ff, rsp_in;

   logic              ram_we, ram_re;
   logic [IDX_W-1:0]  ram_waddr, ram_raddr;
   logic [7:0]        ram_wdata, ram_rdata;

   logic [IDX_W-1:0]  put_next, pop_next;
   logic              put_full, empty, out_free, do_put;
   logic [7:0]        put_byte, col_byte, locate_value;
   logic [6:0]        line_addr;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return i + 1'b1;
   endfunction

   lcdq_ram #(
      .WIDTH (8),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ring pointers
   assign put_next = next_idx(wr_ff);
   assign pop_next = next_idx(rd_ff);
   assign put_full = (put_next == rd_ff);
   assign empty    = (wr_ff == rd_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // row base lookup, rows outside the row count go in raw
   always_comb begin
      line_addr = {3'd0, row_ff};
      if (row_ff == 4'd0) begin
         line_addr = cfg.line_one_base;
      end else if (row_ff == 4'd1 && cfg.row_count > 3'd1) begin
         line_addr = cfg.line_two_base;
      end else if (row_ff == 4'd2 && cfg.row_count > 3'd2) begin
         line_addr = cfg.line_three_base;
      end else if (row_ff == 4'd3 && cfg.row_count > 3'd3) begin
         line_addr = cfg.line_four_base;
      end
   end

   assign col_byte     = col_zero_ff ? 8'd0 : ram_rdata;
   assign locate_value = 8'(lcdq_pkg::CMD_SET_ADDR + {1'b0, line_addr} + col_byte);

   // sequencer: puts, pops and decode
   always_comb begin
      state_in     = state_ff;
      wr_in        = wr_ff;
      rd_in        = rd_ff;
      second_in    = second_ff;
      row_in       = row_ff;
      col_zero_in  = col_zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      op_ready     = (state_ff == S_IDLE);
      do_put       = 1'b0;
      put_byte     = op_data.first_byte;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = pop_next;

      case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               case (op_data.op)
                  lcdq_pkg::OP_PUT_ONE: begin
                     do_put = 1'b1;
                  end
                  lcdq_pkg::OP_PUT_TWO: begin
                     do_put    = 1'b1;
                     second_in = op_data.second_byte;
                     state_in  = S_PUT2;
                  end
                  lcdq_pkg::OP_SERVICE: begin
                     if (!empty) begin
                        rd_in    = pop_next;
                        ram_re   = 1'b1;
                        state_in = S_DECODE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PUT2: begin
            put_byte = second_ff;
            do_put   = 1'b1;
            state_in = S_IDLE;
         end
         S_DECODE: begin
            if (ram_rdata == 8'd0) begin
               state_in = S_IDLE;
            end else if (!ram_rdata[7]) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{kind: lcdq_pkg::KIND_DATA, value: ram_rdata, long_wait: 1'b0};
                  state_in     = S_IDLE;
               end
            end else begin
               case (ram_rdata[6:4])
                  lcdq_pkg::CLASS_HOME: begin
                     if (out_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{kind: lcdq_pkg::KIND_PAUSE, value: 8'd0,
                                         long_wait: 1'b1};
                        state_in     = S_IDLE;
                     end
                  end
                  lcdq_pkg::CLASS_CLEAR: begin
                     if (out_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{kind: lcdq_pkg::KIND_CMD, value: lcdq_pkg::CMD_CLEAR,
                                         long_wait: 1'b1};
                        state_in     = S_IDLE;
                     end
                  end
                  lcdq_pkg::CLASS_LOCATE: begin
                     row_in      = ram_rdata[3:0];
                     col_zero_in = empty;
                     if (!empty) begin
                        rd_in  = pop_next;
                        ram_re = 1'b1;
                     end
                     state_in = S_LOCATE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_LOCATE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{kind: lcdq_pkg::KIND_CMD, value: locate_value, long_wait: 1'b0};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a put into a full ring empties it and drops the byte
      if (do_put) begin
         if (put_full) begin
            wr_in = rd_ff;
         end else begin
            wr_in  = put_next;
            ram_we = 1'b1;
         end
      end
   end

   assign ram_waddr = put_next;
   assign ram_wdata = put_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_ff        <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         col_zero_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
         col_zero_ff  <= col_zero_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      second_ff <= second_in;
      row_ff    <= row_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("ring written and read in one cycle");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ram_re |-> (wr_ff != rd_ff))
      else $error("pop from an empty ring");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (wr_ff <= IDX_W'(QUEUE_DEPTH - 1)) && (rd_ff <= IDX_W'(QUEUE_DEPTH - 1)))
      else $error("ring index out of range");

   a_data_short_wait: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == lcdq_pkg::KIND_DATA) |-> !rsp_ff.long_wait)
      else $error("data beat flagged with long wait");
`endif

endmodule

// ===== rtl/core/lcd_command_queue_decoder_top.sv =====
// character display command queue and decoder
//
// req channel (valid/ready): one beat per put or service request. puts store
// one byte (two for locate) in a ring of QUEUE_DEPTH bytes; a service beat
// pops one byte (two for a locate) and decodes it into at most one rsp beat.
// rsp channel (valid/ready): command write, data write or pause, with the
// long wait flag. puts and empty or silent pops give no rsp beat.
// csr port: write enable, register index and data; the user writes it only while
// idle, which the block itself does not enforce.
// requests pass a two-entry operation queue into a sequencer that owns the
// ring memory, which has one write and one registered read port.
// a put is stored from S_IDLE, the second byte of a locate put from S_PUT2.
// a service pops in S_IDLE and decodes in S_DECODE, and a locate token goes on
// to S_LOCATE, which reads the column through the same read port; the rsp beat
// is registered in the rsp output register. req_ready drops only when the
// operation queue is full. a held rsp beat stalls the sequencer at decode or
// locate; the operation queue keeps taking requests until it fills.
// reset clears the ring pointers, queue pointers and config registers to their
// defaults; ring contents and payload registers are kept, with no clearing pass.
module lcd_command_queue_decoder_top #(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  lcdq_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output lcdq_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write_en,
   input  logic [lcdq_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lcdq_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   lcdq_pkg::cfg_type cfg_ff, cfg_in;
   lcdq_pkg::op_type  op_data;
   logic              op_valid, op_ready;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            lcdq_pkg::CSR_ROW_COUNT:       cfg_in.row_count       = csr_wdata[2:0];
            lcdq_pkg::CSR_LINE_ONE_BASE:   cfg_in.line_one_base   = csr_wdata;
            lcdq_pkg::CSR_LINE_TWO_BASE:   cfg_in.line_two_base   = csr_wdata;
            lcdq_pkg::CSR_LINE_THREE_BASE: cfg_in.line_three_base = csr_wdata;
            lcdq_pkg::CSR_LINE_FOUR_BASE:  cfg_in.line_four_base  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_count       <= lcdq_pkg::ROW_COUNT_RESET;
         cfg_ff.line_one_base   <= lcdq_pkg::LINE_ONE_BASE_RESET;
         cfg_ff.line_two_base   <= lcdq_pkg::LINE_TWO_BASE_RESET;
         cfg_ff.line_three_base <= lcdq_pkg::LINE_THREE_BASE_RESET;
         cfg_ff.line_four_base  <= lcdq_pkg::LINE_FOUR_BASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request classification and operation queue
   lcdq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .op_valid  (op_valid),
      .op_ready  (op_ready),
      .op_data   (op_data)
   );

   // ring sequencer and decoder
   lcdq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op_ready  (op_ready),
      .op_data   (op_data),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== verif/tb_lcd_command_queue_decoder_top.sv =====
`timescale 1ns / 100ps

module tb_lcd_command_queue_decoder_top;

   localparam int         RING_DEPTH       = 256;
   localparam int         SETTLE_CYCLES    = 20;
   localparam int         HOLDOFF_CYCLES   = 300;
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

   typedef logic [lcdq_pkg::CSR_DATA_W-1:0] csr_word_type;

   logic                              clock;
   logic                              reset        = 1'b1;
   logic                              req_valid    = 1'b0;
   logic                              req_ready;
   lcdq_pkg::req_type                 req_data     = '0;
   logic                              rsp_valid;
   logic                              rsp_ready    = 1'b0;
   lcdq_pkg::rsp_type                 rsp_data;
   logic                              csr_write_en = 1'b0;
   logic [lcdq_pkg::CSR_INDEX_W-1:0]  csr_index    = '0;
   logic [lcdq_pkg::CSR_DATA_W-1:0]   csr_wdata    = '0;

   // stimulus and checking state
   lcdq_pkg::req_type queued_requests[$];
   lcdq_pkg::rsp_type expected_actions[$];
   int                error_count   = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   logic              holdoff_start = 1'b0;
   logic              rsp_hold      = 1'b0;

   // shadow of the ring and the registers
   logic [7:0]        ring_bytes [RING_DEPTH];
   logic [7:0]        ring_wr = 8'd0;
   logic [7:0]        ring_rd = 8'd0;
   lcdq_pkg::cfg_type shadow_cfg = '{row_count: lcdq_pkg::ROW_COUNT_RESET,
                                     line_one_base: lcdq_pkg::LINE_ONE_BASE_RESET,
                                     line_two_base: lcdq_pkg::LINE_TWO_BASE_RESET,
                                     line_three_base: lcdq_pkg::LINE_THREE_BASE_RESET,
                                     line_four_base: lcdq_pkg::LINE_FOUR_BASE_RESET};

   lcd_command_queue_decoder_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin : clock_gen
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ring push: a full ring is emptied and the byte dropped
   function automatic void ring_push(logic [7:0] b);
      logic [7:0] nxt;
      nxt = ring_wr + 8'd1;
      if (nxt == ring_rd) begin
         ring_wr = ring_rd;
      end else begin
         ring_wr = nxt;
         ring_bytes[nxt] = b;
      end
   endfunction

   // ring pop: empty ring reads as zero
   function automatic logic [7:0] ring_pop();
      if (ring_wr == ring_rd) return 8'h00;
      ring_rd = ring_rd + 8'd1;
      return ring_bytes[ring_rd];
   endfunction

   // rows beyond row_count fall back to the raw row number
   function automatic logic [7:0] line_address(logic [3:0] r);
      if (r == 4'd0) return {1'b0, shadow_cfg.line_one_base};
      if (r == 4'd1 && shadow_cfg.row_count > 3'd1) return {1'b0, shadow_cfg.line_two_base};
      if (r == 4'd2 && shadow_cfg.row_count > 3'd2) return {1'b0, shadow_cfg.line_three_base};
      if (r == 4'd3 && shadow_cfg.row_count > 3'd3) return {1'b0, shadow_cfg.line_four_base};
      return {4'd0, r};
   endfunction

   // works out the display action, if any, of one accepted request
   function automatic void predict_display_action(lcdq_pkg::req_type r);
      logic [7:0]        tok;
      logic [7:0]        col;
      lcdq_pkg::rsp_type act;
      case (r.mode)
         lcdq_pkg::MODE_PUT_CHAR: begin
            if (r.char_code >= lcdq_pkg::GLYPH_FIRST && r.char_code <= lcdq_pkg::GLYPH_LAST)
               ring_push({5'd0, r.char_code[2:0]});
            else
               ring_push(r.char_code);
         end
         lcdq_pkg::MODE_PUT_CLEAR: ring_push(lcdq_pkg::TOKEN_CLEAR);
         lcdq_pkg::MODE_PUT_HOME: ring_push(lcdq_pkg::TOKEN_HOME);
         lcdq_pkg::MODE_PUT_LOCATE: begin
            ring_push({lcdq_pkg::TOKEN_LOCATE_HI, r.row});
            ring_push(r.column);
         end
         lcdq_pkg::MODE_SERVICE: begin
            tok = ring_pop();
            if (tok != 8'h00) begin
               if (!tok[7]) begin
                  act = '{kind: lcdq_pkg::KIND_DATA, value: tok, long_wait: 1'b0};
                  expected_actions.push_back(act);
               end else begin
                  case (tok[6:4])
                     lcdq_pkg::CLASS_HOME: begin
                        act = '{kind: lcdq_pkg::KIND_PAUSE, value: 8'h00, long_wait: 1'b1};
                        expected_actions.push_back(act);
                     end
                     lcdq_pkg::CLASS_CLEAR: begin
                        act = '{kind: lcdq_pkg::KIND_CMD, value: lcdq_pkg::CMD_CLEAR,
                                long_wait: 1'b1};
                        expected_actions.push_back(act);
                     end
                     lcdq_pkg::CLASS_LOCATE: begin
                        col = ring_pop();
                        act = '{kind: lcdq_pkg::KIND_CMD,
                                value: lcdq_pkg::CMD_SET_ADDR + line_address(tok[3:0]) + col,
                                long_wait: 1'b0};
                        expected_actions.push_back(act);
                     end
                     default: ;
                  endcase
               end
            end
         end
         default: ;
      endcase
   endfunction

   // request driver, predicting on each accepted beat
   always @(posedge clock) begin : request_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_display_action(req_data);
         if (!req_valid || req_ready) begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= queued_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response acceptance with random stalls
   always @(posedge clock) begin : response_sink
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // long receiver hold-off so the operation queue fills and stalls input
   initial begin : receiver_holdoff
      int held;
      wait (holdoff_start);
      @(posedge clock);
      rsp_hold <= 1'b1;
      for (held = 0; held < HOLDOFF_CYCLES; held++) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic report_mismatch(string what);
      error_count++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   // compare each response beat with the oldest expected action
   always @(posedge clock) begin : action_checker
      lcdq_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_actions.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %0d value 0x%02h wait %0b",
                                      rsp_data.kind, rsp_data.value, rsp_data.long_wait));
         end else begin
            want = expected_actions.pop_front();
            if (rsp_data.kind !== want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", rsp_data.kind, want.kind));
            if (rsp_data.value !== want.value)
               report_mismatch($sformatf("value 0x%02h, want 0x%02h",
                                         rsp_data.value, want.value));
            if (rsp_data.long_wait !== want.long_wait)
               report_mismatch($sformatf("long_wait %0b, want %0b",
                                         rsp_data.long_wait, want.long_wait));
         end
      end
   end

   function automatic lcdq_pkg::req_type make_req(logic [2:0] m, logic [7:0] ch,
                                                  logic [3:0] r, logic [7:0] col);
      lcdq_pkg::req_type q;
      q.mode      = m;
      q.char_code = ch;
      q.row       = r;
      q.column    = col;
      return q;
   endfunction

   // register write, only while the block is idle
   task automatic write_reg(logic [lcdq_pkg::CSR_INDEX_W-1:0] idx,
                            logic [lcdq_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      case (idx)
         lcdq_pkg::CSR_ROW_COUNT:       shadow_cfg.row_count       = data[2:0];
         lcdq_pkg::CSR_LINE_ONE_BASE:   shadow_cfg.line_one_base   = data;
         lcdq_pkg::CSR_LINE_TWO_BASE:   shadow_cfg.line_two_base   = data;
         lcdq_pkg::CSR_LINE_THREE_BASE: shadow_cfg.line_three_base = data;
         lcdq_pkg::CSR_LINE_FOUR_BASE:  shadow_cfg.line_four_base  = data;
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_config(int rows, int b1, int b2, int b3, int b4);
      write_reg(lcdq_pkg::CSR_ROW_COUNT, csr_word_type'(rows));
      write_reg(lcdq_pkg::CSR_LINE_ONE_BASE, csr_word_type'(b1));
      write_reg(lcdq_pkg::CSR_LINE_TWO_BASE, csr_word_type'(b2));
      write_reg(lcdq_pkg::CSR_LINE_THREE_BASE, csr_word_type'(b3));
      write_reg(lcdq_pkg::CSR_LINE_FOUR_BASE, csr_word_type'(b4));
   endtask

   // mixed puts, services and spare modes with random content
   task automatic queue_mixed_traffic(int count);
      int         pick;
      logic [2:0] m;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 32)      m = lcdq_pkg::MODE_PUT_CHAR;
         else if (pick < 37) m = lcdq_pkg::MODE_PUT_CLEAR;
         else if (pick < 42) m = lcdq_pkg::MODE_PUT_HOME;
         else if (pick < 57) m = lcdq_pkg::MODE_PUT_LOCATE;
         else if (pick < 96) m = lcdq_pkg::MODE_SERVICE;
         else                m = 3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
         queued_requests.push_back(make_req(m, 8'($urandom_range(255)),
                                            4'($urandom_range(15)),
                                            8'($urandom_range(255))));
      end
   endtask

   // enough character puts to overflow the ring and wipe it
   task automatic queue_fill_burst(int count);
      repeat (count)
         queued_requests.push_back(make_req(lcdq_pkg::MODE_PUT_CHAR,
                                            8'($urandom_range(127, 1)),
                                            4'($urandom_range(15)),
                                            8'($urandom_range(255))));
   endtask

   // sender stops until every expected action has come, then the block settles
   task automatic wait_until_idle();
      while (queued_requests.size() != 0 || req_valid || expected_actions.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int m;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty service, extreme characters, every token, spare modes
      queued_requests.push_back(make_req(lcdq_pkg::MODE_SERVICE, 8'h00, 4'd0, 8'h00));
      queued_requests.push_back(make_req(lcdq_pkg::MODE_PUT_CHAR, 8'h7F, 4'd0, 8'h00));
      queued_requests.push_back(make_req(lcdq_pkg::MODE_PUT_CHAR, lcdq_pkg::GLYPH_FIRST,
                                         4'd0, 8'h00));
      queued_requests.push_back(make_req(lcdq_pkg::MODE_PUT_CHAR, lcdq_pkg::GLYPH_LAST,
                                         4'd0, 8'h00));
      queued_requests.push_back(make_req(lcdq_pkg::MODE_PUT_CHAR, 8'h88, 4'd0, 8'h00));
      queued_requests.push_back(make_req(lcdq_pkg::MODE_PUT_CHAR, 8'hFF, 4'd0, 8'h00));
      queued_requests.push_back(make_req(lcdq_pkg::MODE_PUT_CLEAR, 8'h00, 4'd0, 8'h00));
      queued_requests.push_back(make_req(lcdq_pkg::MODE_PUT_HOME, 8'h00, 4'd0, 8'h00));
      queued_requests.push_back(make_req(lcdq_pkg::MODE_PUT_LOCATE, 8'h00, 4'd0, 8'h00));
      queued_requests.push_back(make_req(lcdq_pkg::MODE_PUT_LOCATE, 8'h00, 4'd3, 8'hFF));
      queued_requests.push_back(make_req(lcdq_pkg::MODE_PUT_LOCATE, 8'h00, 4'd15, 8'h7F));
      for (m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
         queued_requests.push_back(make_req(3'(m), 8'hFF, 4'd15, 8'hFF));
      // locate token as a raw character, with no column behind it
      queued_requests.push_back(make_req(lcdq_pkg::MODE_PUT_CHAR, 8'hA5, 4'd0, 8'h00));
      repeat (12)
         queued_requests.push_back(make_req(lcdq_pkg::MODE_SERVICE, 8'h00, 4'd0, 8'h00));
      wait_until_idle();

      // sender light, receiver heavy idling, with a long receiver hold-off
      send_idle_pct = 23;
      recv_idle_pct = 71;
      set_config(1, 0, 127, 0, 127);
      holdoff_start = 1'b1;
      queue_mixed_traffic(150);
      wait_until_idle();

      set_config(4, 127, 0, 127, 0);
      queue_mixed_traffic(150);
      wait_until_idle();

      // sender heavy, receiver light idling
      send_idle_pct = 71;
      recv_idle_pct = 23;
      set_config(3, $urandom_range(127), $urandom_range(127), $urandom_range(127),
                 $urandom_range(127));
      queue_mixed_traffic(130);
      wait_until_idle();

      set_config(2, $urandom_range(127), $urandom_range(127), $urandom_range(127),
                 $urandom_range(127));
      queue_fill_burst(258);
      queue_mixed_traffic(60);
      wait_until_idle();

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(4, $urandom_range(127), $urandom_range(127), $urandom_range(127),
                 $urandom_range(127));
      queue_mixed_traffic(120);
      wait_until_idle();
      queue_mixed_traffic(80);
      wait_until_idle();

      if (error_count == 0 && expected_actions.size() == 0)
         $display("tb_lcd_command_queue_decoder_top: PASS");
      else
         $display("tb_lcd_command_queue_decoder_top: FAIL");
      $finish;
   end

   initial begin : run_limit
      #2000000;
      $display("tb_lcd_command_queue_decoder_top: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/lcdq_pkg.sv
rtl/core/lcdq_ram.sv
rtl/core/lcdq_front.sv
rtl/core/lcdq_back.sv
rtl/core/lcd_command_queue_decoder_top.sv
verif/tb_lcd_command_queue_decoder_top.sv
